[hw/rtl/keypad_pressed_key_tracker_defines.svh]
// Assertion macros for the keypad pressed-key tracker.
`ifndef KEYPAD_PRESSED_KEY_TRACKER_DEFINES_SVH
`define KEYPAD_PRESSED_KEY_TRACKER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define KPT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("kpt assertion failed");

// Next-cycle implication, checked outside reset.
`define KPT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("kpt assertion failed");

`endif

[hw/rtl/kpt_pkg.sv]
// Shared widths, types and the key code decoder of the pressed-key tracker.
`default_nettype none

package kpt_pkg;

    localparam int KPT_LIST_DEPTH = 8;

    localparam int EV_W      = 8;
    localparam int DT_W      = 20;
    localparam int SLOT_W    = 3;
    localparam int ROW_W     = 3;
    localparam int COL_W     = 4;
    localparam int HOLD_W    = 32;
    localparam int CNT_OUT_W = 4;
    localparam int CODE_W    = 7;
    localparam int ENTRY_W   = ROW_W + COL_W + HOLD_W;

    localparam int                PRESS_BIT    = 7;
    localparam logic [CODE_W-1:0] KEY_CODE_MAX = 7'd80;
    localparam logic [3:0]        COL_COUNT    = 4'd10;
    // floor(x / 10) == (x * 205) >> 11 for x below 80
    localparam logic [7:0]        DIV10_MUL    = 8'd205;
    localparam int                DIV10_SHIFT  = 11;

    typedef struct packed {
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic [HOLD_W-1:0] hold;
    } t_entry;

    typedef struct packed {
        logic                 event_taken;
        logic                 is_press;
        logic [ROW_W-1:0]     key_row;
        logic [COL_W-1:0]     key_col;
        logic                 code_invalid;
        logic [CNT_OUT_W-1:0] held_count;
        logic                 released_valid;
        logic [ROW_W-1:0]     slot_row;
        logic [COL_W-1:0]     slot_col;
        logic [HOLD_W-1:0]    slot_hold;
        logic                 slot_valid;
    } t_result;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
    } t_key;

    // Key code 1..80 to matrix position.
    function automatic t_key decode_key(input logic [CODE_W-1:0] code);
        logic [CODE_W-1:0] x;
        logic [14:0]       prod;
        logic [CODE_W-1:0] rem;
        t_key              k;
        x     = code - CODE_W'(1);
        prod  = 15'(x) * 15'(DIV10_MUL);
        k.row = prod[DIV10_SHIFT +: ROW_W];
        rem   = x - CODE_W'(k.row) * CODE_W'(COL_COUNT);
        k.col = rem[COL_W-1:0];
        return k;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/kpt_in_if.sv]
// Input channel of the tracker: one event byte, elapsed time and slot query.
`default_nettype none

interface kpt_in_if;
    logic                        valid;
    logic                        ready;
    logic [kpt_pkg::EV_W-1:0]   ev_byte;
    logic [kpt_pkg::DT_W-1:0]   elapsed_us;
    logic [kpt_pkg::SLOT_W-1:0] read_slot;

    modport source (output valid, ev_byte, elapsed_us, read_slot, input ready);
    modport sink   (input valid, ev_byte, elapsed_us, read_slot, output ready);
endinterface

`default_nettype wire

[hw/rtl/kpt_out_if.sv]
// Output channel of the tracker: decode, counts and the queried slot.
`default_nettype none

interface kpt_out_if;
    logic                           valid;
    logic                           ready;
    logic                           event_taken;
    logic                           is_press;
    logic [kpt_pkg::ROW_W-1:0]     key_row;
    logic [kpt_pkg::COL_W-1:0]     key_col;
    logic                           code_invalid;
    logic [kpt_pkg::CNT_OUT_W-1:0] held_count;
    logic                           released_valid;
    logic [kpt_pkg::ROW_W-1:0]     slot_row;
    logic [kpt_pkg::COL_W-1:0]     slot_col;
    logic [kpt_pkg::HOLD_W-1:0]    slot_hold;
    logic                           slot_valid;

    modport source (
        output valid, event_taken, is_press, key_row, key_col, code_invalid,
               held_count, released_valid, slot_row, slot_col, slot_hold, slot_valid,
        input  ready
    );
    modport sink (
        input  valid, event_taken, is_press, key_row, key_col, code_invalid,
               held_count, released_valid, slot_row, slot_col, slot_hold, slot_valid,
        output ready
    );
endinterface

`default_nettype wire

[hw/rtl/kpt_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module kpt_ram #(
    parameter int WIDTH = kpt_pkg::ENTRY_W,
    parameter int DEPTH = kpt_pkg::KPT_LIST_DEPTH,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

[hw/rtl/keypad_pressed_key_tracker.sv]
// Keypad pressed-key tracker: list memory, walk sequencer and result register.
//
// Each transaction carries one keypad event byte. A press appends the key to a
// list of LIST_DEPTH held keys kept in a single-port-read RAM; a release removes
// the first matching entry and closes the gap; a zero byte (tick) adds the
// elapsed microseconds, saturating, to every held key's time. Each transaction
// yields one result with the decode, the list count and the entry at read_slot.
// A press, an invalid code, or a tick/release on an empty list goes from the
// idle state through the slot read and the response state into the result
// register, and the input is ready again once the result loads. A tick or a
// release on a list of N entries (the count before the step) walks the RAM one
// entry per cycle through its one read port, then reads the slot and responds.
// The last step waits while the previous result still sits unclaimed in the
// output register.
// The next transaction is accepted while a result still waits on the output.
`default_nettype none

module keypad_pressed_key_tracker #(
    parameter int LIST_DEPTH = kpt_pkg::KPT_LIST_DEPTH
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    kpt_in_if.sink    i_in,
    kpt_out_if.source o_out
);
    import kpt_pkg::*;

    `include "keypad_pressed_key_tracker_defines.svh"

    localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CW = $clog2(LIST_DEPTH + 1);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_WALK = 4'b0010,
        ST_SLOT = 4'b0100,
        ST_RESP = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic [CW-1:0] r_total, n_total;
    logic [CW-1:0] r_idx, n_idx;
    logic [CW-1:0] r_rd_idx, n_rd_idx;
    logic r_rd_vld, n_rd_vld;
    logic r_found, n_found;
    logic r_is_tick, n_is_tick;
    logic [DT_W-1:0] r_dt, n_dt;
    logic [SLOT_W-1:0] r_slot, n_slot;
    logic r_slot_vld, n_slot_vld;
    t_result r_res, n_res;
    t_result r_out, n_out;
    logic r_out_valid, n_out_valid;

    logic accept;
    logic [CODE_W-1:0] in_code;
    logic in_tick, in_press, in_bad, in_rel;
    t_key in_key;

    logic ram_we, ram_re;
    logic [AW-1:0] ram_waddr, ram_raddr;
    t_entry ram_wdata, ram_rdata;

    logic [CW-1:0] rd_idx_m1;
    logic [HOLD_W:0] hold_sum;
    logic [HOLD_W-1:0] hold_sat;
    logic match;
    logic [31:0] total_ext, slot_ext;

    kpt_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(LIST_DEPTH),
        .AW   (AW)
    ) u_list_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_re   (ram_re),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    assign i_in.ready = (r_state == ST_IDLE);
    assign accept     = i_in.valid && (r_state == ST_IDLE);

    assign in_code  = i_in.ev_byte[CODE_W-1:0];
    assign in_tick  = (i_in.ev_byte == '0);
    assign in_press = i_in.ev_byte[PRESS_BIT];
    assign in_bad   = !in_tick && ((in_code == '0) || (in_code > KEY_CODE_MAX));
    assign in_rel   = !in_tick && !in_bad && !in_press;
    assign in_key   = decode_key(in_code);

    assign rd_idx_m1 = r_rd_idx - CW'(1);
    assign hold_sum  = {1'b0, ram_rdata.hold} + (HOLD_W + 1)'(r_dt);
    assign hold_sat  = hold_sum[HOLD_W] ? '1 : hold_sum[HOLD_W-1:0];
    assign match     = (ram_rdata.row == r_res.key_row) && (ram_rdata.col == r_res.key_col);
    assign total_ext = 32'(r_total);
    assign slot_ext  = 32'(r_slot);

    always_comb begin
        n_state     = r_state;
        n_total     = r_total;
        n_idx       = r_idx;
        n_rd_idx    = r_rd_idx;
        n_rd_vld    = r_rd_vld;
        n_found     = r_found;
        n_is_tick   = r_is_tick;
        n_dt        = r_dt;
        n_slot      = r_slot;
        n_slot_vld  = r_slot_vld;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid && !o_out.ready;
        ram_we      = 1'b0;
        ram_waddr   = '0;
        ram_wdata   = '0;
        ram_re      = 1'b0;
        ram_raddr   = '0;

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_dt      = i_in.elapsed_us;
                    n_slot    = i_in.read_slot;
                    n_is_tick = in_tick;
                    n_idx     = '0;
                    n_rd_vld  = 1'b0;
                    n_found   = 1'b0;
                    n_res     = '0;
                    n_res.event_taken    = !in_tick;
                    n_res.is_press       = in_press;
                    n_res.code_invalid   = in_bad;
                    n_res.released_valid = in_rel;
                    if (!in_tick && !in_bad) begin
                        n_res.key_row = in_key.row;
                        n_res.key_col = in_key.col;
                    end
                    if (in_tick || in_rel) begin
                        n_state = (r_total == '0) ? ST_SLOT : ST_WALK;
                    end else begin
                        // press into a free slot: write the new tail entry now
                        if (!in_bad && in_press && (r_total < CW'(LIST_DEPTH))) begin
                            ram_we         = 1'b1;
                            ram_waddr      = r_total[AW-1:0];
                            ram_wdata.row  = in_key.row;
                            ram_wdata.col  = in_key.col;
                            ram_wdata.hold = '0;
                            n_total        = r_total + CW'(1);
                        end
                        n_state = ST_SLOT;
                    end
                end
            end
            ST_WALK: begin
                // read entry r_idx while entry r_rd_idx comes back from the RAM
                if (r_idx != r_total) begin
                    ram_re    = 1'b1;
                    ram_raddr = r_idx[AW-1:0];
                    n_idx     = r_idx + CW'(1);
                    n_rd_idx  = r_idx;
                    n_rd_vld  = 1'b1;
                end else begin
                    n_rd_vld = 1'b0;
                end
                if (r_rd_vld) begin
                    if (r_is_tick) begin
                        ram_we         = 1'b1;
                        ram_waddr      = r_rd_idx[AW-1:0];
                        ram_wdata.row  = ram_rdata.row;
                        ram_wdata.col  = ram_rdata.col;
                        ram_wdata.hold = hold_sat;
                    end else if (r_found) begin
                        // compaction: move each later entry down by one
                        ram_we    = 1'b1;
                        ram_waddr = rd_idx_m1[AW-1:0];
                        ram_wdata = ram_rdata;
                    end else if (match) begin
                        n_found = 1'b1;
                    end
                    if (r_idx == r_total) begin
                        if (!r_is_tick && (r_found || match)) begin
                            n_total = r_total - CW'(1);
                        end
                        n_state = ST_SLOT;
                    end
                end
            end
            ST_SLOT: begin
                ram_re     = 1'b1;
                ram_raddr  = slot_ext[AW-1:0];
                n_slot_vld = (slot_ext < total_ext);
                n_state    = ST_RESP;
            end
            ST_RESP: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out            = r_res;
                    n_out.held_count = total_ext[CNT_OUT_W-1:0];
                    n_out.slot_valid = r_slot_vld;
                    if (r_slot_vld) begin
                        n_out.slot_row  = ram_rdata.row;
                        n_out.slot_col  = ram_rdata.col;
                        n_out.slot_hold = ram_rdata.hold;
                    end
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_total     <= '0;
            r_idx       <= '0;
            r_rd_vld    <= 1'b0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_total     <= n_total;
            r_idx       <= n_idx;
            r_rd_vld    <= n_rd_vld;
            r_found     <= n_found;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx   <= n_rd_idx;
        r_is_tick  <= n_is_tick;
        r_dt       <= n_dt;
        r_slot     <= n_slot;
        r_slot_vld <= n_slot_vld;
        r_res      <= n_res;
        r_out      <= n_out;
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.event_taken    = r_out.event_taken;
    assign o_out.is_press       = r_out.is_press;
    assign o_out.key_row        = r_out.key_row;
    assign o_out.key_col        = r_out.key_col;
    assign o_out.code_invalid   = r_out.code_invalid;
    assign o_out.held_count     = r_out.held_count;
    assign o_out.released_valid = r_out.released_valid;
    assign o_out.slot_row       = r_out.slot_row;
    assign o_out.slot_col       = r_out.slot_col;
    assign o_out.slot_hold      = r_out.slot_hold;
    assign o_out.slot_valid     = r_out.slot_valid;

    `KPT_ASSERT_NOW(a_total_bound, i_clk, i_rst_n, 1'b1, r_total <= CW'(LIST_DEPTH))
    `KPT_ASSERT_NOW(a_no_rw_collide, i_clk, i_rst_n, ram_we && ram_re, ram_waddr != ram_raddr)
    `KPT_ASSERT_NEXT(a_accept_leaves_idle, i_clk, i_rst_n, accept, r_state != ST_IDLE)
    `KPT_ASSERT_NEXT(a_resp_drives_out, i_clk, i_rst_n,
        (r_state == ST_RESP) && (!r_out_valid || o_out.ready), o_out.valid)

endmodule

`default_nettype wire

[tb/tb_keypad_pressed_key_tracker.sv]
// Self-checking testbench for the keypad pressed-key tracker.
`timescale 1ns / 100ps

module tb_keypad_pressed_key_tracker;
    import kpt_pkg::*;

    localparam int CLK_HALF         = 10;
    localparam int RESET_CYCLES     = 11;
    localparam int WATCHDOG_LIMIT   = 2000;
    localparam int DRAIN_CYCLES     = 24;
    localparam int RANDOM_EVENTS    = 1400;
    localparam int SATURATION_TICKS = 200;
    localparam int QUIET_TAIL       = 300;
    localparam int MAX_REPORTS      = 10;
    localparam int LAST_KEY_CODE    = 80;
    localparam int HIGHEST_CODE     = 127;
    localparam int KEYS_PER_ROW     = 10;

    localparam logic [EV_W-1:0] TIME_TICK  = 8'h00;
    localparam logic [EV_W-1:0] PRESS_FLAG = 8'h80;
    localparam logic [DT_W-1:0] DT_MAX     = '1;

    typedef struct packed {
        logic [EV_W-1:0]   ev_byte;
        logic [DT_W-1:0]   elapsed_us;
        logic [SLOT_W-1:0] read_slot;
    } t_key_txn;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    kpt_in_if  in_ch ();
    kpt_out_if out_ch ();

    keypad_pressed_key_tracker DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    t_key_txn pending_events[$];
    t_result  expected_results[$];
    int       gen_held[$];

    int total_events  = 0;
    int accepted_cnt  = 0;
    int sent_cnt      = 0;
    int results_seen  = 0;
    int mismatches    = 0;
    int idle_cycles   = 0;
    int send_gap      = 0;
    int recv_gap      = 0;
    bit in_fire       = 1'b0;

    // Predicted pressed-key list
    logic [ROW_W-1:0]  held_row  [KPT_LIST_DEPTH];
    logic [COL_W-1:0]  held_col  [KPT_LIST_DEPTH];
    logic [HOLD_W-1:0] held_hold [KPT_LIST_DEPTH];
    int                held_len = 0;

    function automatic t_result track_txn(input t_key_txn t);
        t_result           r;
        int                code;
        int                hit;
        logic [HOLD_W:0]   sum;
        r    = '0;
        hit  = -1;
        code = int'(t.ev_byte[CODE_W-1:0]);
        if (t.ev_byte == TIME_TICK) begin
            for (int k = 0; k < held_len; k++) begin
                sum = {1'b0, held_hold[k]} + (HOLD_W+1)'(t.elapsed_us);
                held_hold[k] = sum[HOLD_W] ? '1 : sum[HOLD_W-1:0];
            end
        end else begin
            r.event_taken = 1'b1;
            r.is_press    = t.ev_byte[PRESS_BIT];
            if (code == 0 || code > LAST_KEY_CODE) begin
                r.code_invalid = 1'b1;
            end else begin
                r.key_row = ROW_W'((code - 1) / KEYS_PER_ROW);
                r.key_col = COL_W'((code - 1) % KEYS_PER_ROW);
                if (r.is_press) begin
                    if (held_len < KPT_LIST_DEPTH) begin
                        held_row[held_len]  = r.key_row;
                        held_col[held_len]  = r.key_col;
                        held_hold[held_len] = '0;
                        held_len++;
                    end
                end else begin
                    r.released_valid = 1'b1;
                    for (int k = 0; k < held_len; k++) begin
                        if (hit < 0 && held_row[k] == r.key_row && held_col[k] == r.key_col)
                            hit = k;
                    end
                    // close the gap, order kept
                    if (hit >= 0) begin
                        for (int k = hit; k < held_len - 1; k++) begin
                            held_row[k]  = held_row[k+1];
                            held_col[k]  = held_col[k+1];
                            held_hold[k] = held_hold[k+1];
                        end
                        held_len--;
                    end
                end
            end
        end
        r.held_count = CNT_OUT_W'(held_len);
        if (int'(t.read_slot) < held_len) begin
            r.slot_row   = held_row[t.read_slot];
            r.slot_col   = held_col[t.read_slot];
            r.slot_hold  = held_hold[t.read_slot];
            r.slot_valid = 1'b1;
        end
        return r;
    endfunction

    // Queues one event and keeps a rough copy of the held keys for picking releases.
    task automatic queue_event(input logic [EV_W-1:0] ev, input logic [DT_W-1:0] dt,
                               input logic [SLOT_W-1:0] slot);
        t_key_txn t;
        int       code;
        int       hit;
        t.ev_byte    = ev;
        t.elapsed_us = dt;
        t.read_slot  = slot;
        pending_events.push_back(t);
        code = int'(ev[CODE_W-1:0]);
        hit  = -1;
        if (ev != TIME_TICK && code >= 1 && code <= LAST_KEY_CODE) begin
            if (ev[PRESS_BIT]) begin
                if (gen_held.size() < KPT_LIST_DEPTH)
                    gen_held.push_back(code);
            end else begin
                foreach (gen_held[k]) begin
                    if (hit < 0 && gen_held[k] == code)
                        hit = k;
                end
                if (hit >= 0)
                    gen_held.delete(hit);
            end
        end
    endtask

    task automatic check_field(input string label, input logic [31:0] want_v,
                               input logic [31:0] got_v);
        if (want_v !== got_v) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("result %0d: %s expected %0h, got %0h",
                         results_seen, label, want_v, got_v);
        end
    endtask

    function automatic bit idling_off(input int n);
        return n >= total_events - QUIET_TAIL || (n % 500) >= 400;
    endfunction

    // Driver: inputs and ready change on the falling edge
    always @(negedge i_clk) begin : drive_proc
        t_key_txn nxt;
        if (!i_rst_n) begin
            in_ch.valid      <= 1'b0;
            in_ch.ev_byte    <= '0;
            in_ch.elapsed_us <= '0;
            in_ch.read_slot  <= '0;
            out_ch.ready     <= 1'b0;
        end else begin
            if (!in_ch.valid || in_fire) begin
                if (send_gap != 0) begin
                    in_ch.valid <= 1'b0;
                    send_gap    <= send_gap - 1;
                end else if (pending_events.size() != 0) begin
                    nxt = pending_events.pop_front();
                    in_ch.ev_byte    <= nxt.ev_byte;
                    in_ch.elapsed_us <= nxt.elapsed_us;
                    in_ch.read_slot  <= nxt.read_slot;
                    in_ch.valid      <= 1'b1;
                    sent_cnt         <= sent_cnt + 1;
                    if (!idling_off(sent_cnt) && $urandom_range(0, 4) == 0)
                        send_gap <= $urandom_range(1, 16);
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
            if (recv_gap != 0) begin
                out_ch.ready <= 1'b0;
                recv_gap     <= recv_gap - 1;
            end else begin
                out_ch.ready <= 1'b1;
                if (!idling_off(results_seen) && $urandom_range(0, 5) == 0)
                    recv_gap <= $urandom_range(1, 16);
            end
        end
    end

    // Monitor and scoreboard: everything sampled on the rising edge
    always @(posedge i_clk) begin : check_proc
        t_key_txn got_in;
        t_result  want;
        if (!i_rst_n) begin
            in_fire     <= 1'b0;
            idle_cycles <= 0;
        end else begin
            // results first, so a result never meets an expectation pushed this edge
            if (out_ch.valid && out_ch.ready) begin
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("result %0d arrived with no transaction pending",
                                 results_seen);
                end else begin
                    want = expected_results.pop_front();
                    check_field("event_taken", 32'(want.event_taken),
                                32'(out_ch.event_taken));
                    check_field("is_press", 32'(want.is_press), 32'(out_ch.is_press));
                    check_field("key_row", 32'(want.key_row), 32'(out_ch.key_row));
                    check_field("key_col", 32'(want.key_col), 32'(out_ch.key_col));
                    check_field("code_invalid", 32'(want.code_invalid),
                                32'(out_ch.code_invalid));
                    check_field("held_count", 32'(want.held_count),
                                32'(out_ch.held_count));
                    check_field("released_valid", 32'(want.released_valid),
                                32'(out_ch.released_valid));
                    check_field("slot_row", 32'(want.slot_row), 32'(out_ch.slot_row));
                    check_field("slot_col", 32'(want.slot_col), 32'(out_ch.slot_col));
                    check_field("slot_hold", want.slot_hold, out_ch.slot_hold);
                    check_field("slot_valid", 32'(want.slot_valid),
                                32'(out_ch.slot_valid));
                end
                results_seen <= results_seen + 1;
            end
            if (in_ch.valid && in_ch.ready) begin
                got_in.ev_byte    = in_ch.ev_byte;
                got_in.elapsed_us = in_ch.elapsed_us;
                got_in.read_slot  = in_ch.read_slot;
                expected_results.push_back(track_txn(got_in));
                accepted_cnt <= accepted_cnt + 1;
            end
            in_fire <= in_ch.valid && in_ch.ready;
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
                $display("Verification failed");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin : run_proc
        int               dir_codes[6];
        int               taken_cnt;
        int               pick;
        int               code;
        bit               fill_bias;
        logic [EV_W-1:0]  ev;
        logic [DT_W-1:0]  dt;
        logic [SLOT_W-1:0] slot;

        // Directed: code extremes, invalid codes, repeats, full list, unheld release
        queue_event(TIME_TICK, DT_MAX, 0);
        queue_event(PRESS_FLAG | 8'd1, 0, 0);
        queue_event(PRESS_FLAG | 8'd80, DT_MAX, 1);
        queue_event(TIME_TICK, DT_MAX, 1);
        queue_event(PRESS_FLAG, 0, 0);
        queue_event(PRESS_FLAG | 8'd81, 0, 0);
        queue_event(8'hFF, DT_MAX, 1);
        queue_event(8'd81, 0, 1);
        queue_event(8'h7F, 0, 1);
        queue_event(PRESS_FLAG | 8'd1, 0, 2);
        queue_event(8'd45, 0, 0);
        queue_event(8'd1, 0, 2);
        dir_codes = '{10, 11, 69, 20, 35, 50};
        foreach (dir_codes[k])
            queue_event(PRESS_FLAG | 8'(dir_codes[k]), 20'($urandom), SLOT_W'(k + 2));
        queue_event(PRESS_FLAG | 8'd30, 0, 7);
        queue_event(TIME_TICK, 1, 7);
        queue_event(8'd10, 0, 3);
        queue_event(8'd80, 0, 0);
        queue_event(TIME_TICK, 0, 5);

        // Run of maximal ticks builds large held times
        repeat (SATURATION_TICKS)
            queue_event(TIME_TICK, DT_MAX, SLOT_W'($urandom_range(0, 7)));
        queue_event(PRESS_FLAG | 8'd30, 0, 6);
        repeat (4)
            queue_event(TIME_TICK, DT_MAX, SLOT_W'($urandom_range(0, 7)));

        // Random traffic, mostly presses and releases of held keys
        taken_cnt = 0;
        fill_bias = 1'b1;
        while (taken_cnt < RANDOM_EVENTS) begin
            if (taken_cnt % 60 == 0)
                fill_bias = $urandom_range(0, 1);
            pick = $urandom_range(0, 99);
            slot = SLOT_W'($urandom_range(0, 7));
            if (pick < 8) begin
                code = ($urandom_range(0, 3) == 0) ? 0
                                                   : $urandom_range(LAST_KEY_CODE + 1,
                                                                    HIGHEST_CODE);
                ev = (code == 0) ? PRESS_FLAG
                                 : {1'($urandom_range(0, 1)), CODE_W'(code)};
                queue_event(ev, 20'($urandom), slot);
            end else if (pick < 33) begin
                case ($urandom_range(0, 9))
                    0:       dt = '0;
                    1:       dt = DT_MAX;
                    2, 3:    dt = 20'($urandom);
                    default: dt = 20'($urandom_range(1, 5000));
                endcase
                queue_event(TIME_TICK, dt, slot);
                taken_cnt++;
            end else begin
                if ($urandom_range(0, 99) < (fill_bias ? 70 : 35)) begin
                    code = (gen_held.size() != 0 && $urandom_range(0, 6) == 0)
                         ? gen_held[$urandom_range(0, gen_held.size() - 1)]
                         : $urandom_range(1, LAST_KEY_CODE);
                    ev = PRESS_FLAG | 8'(code);
                end else begin
                    code = (gen_held.size() != 0 && $urandom_range(0, 9) < 8)
                         ? gen_held[$urandom_range(0, gen_held.size() - 1)]
                         : $urandom_range(1, LAST_KEY_CODE);
                    ev = 8'(code);
                end
                queue_event(ev, 20'($urandom), slot);
                taken_cnt++;
            end
        end
        total_events = pending_events.size();

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (accepted_cnt != total_events || expected_results.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (mismatches == 0 && expected_results.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
